// File: hw/rtl/tlt_pkg.sv
// Shared types, constants and translation functions for the tty line translator.
package tlt_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_OUTPUT_FLAGS = 2'd0;
    localparam logic [1:0] REG_INPUT_FLAGS  = 2'd1;
    localparam logic [1:0] REG_LOCAL_FLAGS  = 2'd2;

    localparam logic [3:0] OFLAGS_RESET = 4'd3;
    localparam logic [3:0] IFLAGS_RESET = 4'd8;
    localparam logic [3:0] LFLAGS_RESET = 4'd13;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] CTRL_OFS = 8'h40;

    localparam int MAX_RESULTS = 4;
    localparam logic [2:0] MAX_CNT = 3'd4;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic       action;
        logic [7:0] char_in;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_application;
        logic       last_of_run;
        logic       end_of_write;
    } t_out_item;

    // One classified item: up to four tagged bytes plus the end-of-write mark
    typedef struct packed {
        logic [2:0]       cnt;
        logic [3:0][7:0]  bytes;
        logic [3:0]       app;
        logic             fin;
    } t_entry;

    // Output post-processing of one byte: up to three bytes
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] b;
    } t_seg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_entry add_byte(t_entry e, logic [7:0] b, logic app);
        t_entry r;
        r = e;
        if (r.cnt < MAX_CNT) begin
            r.bytes[r.cnt[1:0]] = b;
            r.app[r.cnt[1:0]]   = app;
            r.cnt               = r.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic t_entry add_seg(t_entry e, t_seg s);
        t_entry r;
        r = e;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < s.cnt) begin
                r = add_byte(r, s.b[k], 1'b0);
            end
        end
        return r;
    endfunction

    function automatic t_seg post_seg(logic [7:0] b, logic echo, logic [3:0] oflags,
                                      logic [3:0] lflags);
        t_seg s;
        s = '0;
        if (b == CH_LF) begin
            if (oflags[0] && oflags[1]) begin
                s.cnt  = 2'd2;
                s.b[0] = CH_CR;
                s.b[1] = CH_LF;
            end else begin
                s.cnt  = 2'd1;
                s.b[0] = CH_LF;
            end
        end else if (b == CH_CR) begin
            if (oflags[0] && oflags[2]) begin
                s.cnt = 2'd0;
            end else begin
                s.cnt  = 2'd1;
                s.b[0] = (oflags[0] && oflags[3]) ? CH_LF : CH_CR;
            end
        end else if (b == CH_BS) begin
            if (echo && lflags[3]) begin
                s.cnt  = 2'd3;
                s.b[0] = CH_BS;
                s.b[1] = CH_SP;
                s.b[2] = CH_BS;
            end else begin
                s.cnt  = 2'd1;
                s.b[0] = CH_BS;
            end
        end else begin
            s.cnt  = 2'd1;
            s.b[0] = b;
        end
        return s;
    endfunction

    function automatic t_entry add_echo(t_entry e, logic [7:0] c, logic [3:0] oflags,
                                        logic [3:0] iflags, logic [3:0] lflags);
        t_entry     r;
        logic [7:0] ec;
        r  = e;
        ec = (c == CH_CR && iflags[3]) ? CH_LF : c;
        if (lflags[0]) begin
            if (lflags[2] && (ec < CH_SP || ec == CH_DEL) && ec != CH_LF && ec != CH_TAB) begin
                r = add_seg(r, post_seg(CH_CARET, 1'b1, oflags, lflags));
                r = add_seg(r, post_seg((ec == CH_DEL) ? CH_QUEST : ec + CTRL_OFS, 1'b1,
                                        oflags, lflags));
            end else begin
                r = add_seg(r, post_seg(ec, 1'b1, oflags, lflags));
            end
        end
        return r;
    endfunction

    function automatic t_entry classify(t_in_item it, logic [3:0] oflags,
                                        logic [3:0] iflags, logic [3:0] lflags);
        t_entry     e;
        logic [7:0] c;
        e     = '0;
        e.fin = it.final_byte;
        c     = it.char_in;
        if (!it.action) begin
            e = add_seg(e, post_seg(c, 1'b0, oflags, lflags));
        end else begin
            if (iflags[0] && c >= CH_UC_A && c <= CH_UC_Z) begin
                c = c + CASE_OFS;
            end
            if (c == CH_LF) begin
                e = add_byte(e, iflags[1] ? CH_CR : CH_LF, 1'b1);
                if (lflags[0] || lflags[1]) begin
                    e = add_seg(e, post_seg(CH_LF, 1'b1, oflags, lflags));
                end
            end else begin
                if (c != CH_CR) begin
                    e = add_byte(e, c, 1'b1);
                end else if (!iflags[2]) begin
                    e = add_byte(e, iflags[3] ? CH_LF : CH_CR, 1'b1);
                end
                e = add_echo(e, c, oflags, iflags, lflags);
            end
        end
        return e;
    endfunction

endpackage

// File: hw/rtl/tty_line_discipline_translate.sv
// Top level of the tty line discipline byte translator.
// Each accepted item is written into the queue, and the back end registers every result beat
// before it drives the ports.
// The back end sends one beat per cycle while the queue holds an entry; an item yields one beat
// per result (up to four), and an item with no results is dropped without a beat.
// A two-entry queue decouples accept from emit; busy is high while it is full.
// Reset (synchronous, active low) restores the flag registers and empties the queue.
module tty_line_discipline_translate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tlt_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [3:0]         i_cfg_wdata,
    output logic               o_strobe,
    output tlt_pkg::t_out_item o_result
);
    import tlt_pkg::*;

    logic    push, pop;
    t_entry  entry, head;
    t_q_stat q_stat;

    assign busy = q_stat.full;

    tlt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (start && !busy),
        .i_item     (i_item),
        .o_push     (push),
        .o_entry    (entry)
    );

    tlt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(entry),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (q_stat)
    );

    tlt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule

// File: hw/rtl/tlt_front.sv
// Front end: configuration registers and classification of accepted bytes.
module tlt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [3:0]        i_cfg_wdata,
    input  logic              i_accept,
    input  tlt_pkg::t_in_item i_item,
    output logic              o_push,
    output tlt_pkg::t_entry   o_entry
);
    import tlt_pkg::*;

    logic [3:0] r_oflags, n_oflags;
    logic [3:0] r_iflags, n_iflags;
    logic [3:0] r_lflags, n_lflags;

    always_comb begin
        n_oflags = r_oflags;
        n_iflags = r_iflags;
        n_lflags = r_lflags;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OUTPUT_FLAGS: n_oflags = i_cfg_wdata;
                REG_INPUT_FLAGS:  n_iflags = i_cfg_wdata;
                REG_LOCAL_FLAGS:  n_lflags = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oflags <= OFLAGS_RESET;
            r_iflags <= IFLAGS_RESET;
            r_lflags <= LFLAGS_RESET;
        end else begin
            r_oflags <= n_oflags;
            r_iflags <= n_iflags;
            r_lflags <= n_lflags;
        end
    end

    assign o_push  = i_accept;
    assign o_entry = classify(i_item, r_oflags, r_iflags, r_lflags);

endmodule

// File: hw/rtl/tlt_queue.sv
// Short queue of classified entries between front and back end.
module tlt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlt_pkg::t_entry i_entry,
    input  logic            i_pop,
    output tlt_pkg::t_entry o_head,
    output tlt_pkg::t_q_stat o_stat
);
    import tlt_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_entry        r_mem [QDEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == CW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QDEPTH)) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty)) else $error("pop from empty queue");

endmodule

// File: hw/rtl/tlt_back.sv
// Back end: emits the bytes of the head entry one per cycle.
module tlt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlt_pkg::t_entry   i_head,
    input  tlt_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    output logic              o_strobe,
    output tlt_pkg::t_out_item o_result
);
    import tlt_pkg::*;

    logic [1:0] r_slot, n_slot;
    logic       r_strobe, n_strobe;
    t_out_item  r_result, n_result;
    logic       is_last;

    assign is_last = ({1'b0, r_slot} + 3'd1 == i_head.cnt);

    always_comb begin
        n_slot   = r_slot;
        n_strobe = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        if (!i_stat.empty) begin
            if (i_head.cnt == '0) begin
                // nothing to send: drop the entry
                o_pop = 1'b1;
            end else begin
                n_strobe                = 1'b1;
                n_result.out_byte       = i_head.bytes[r_slot];
                n_result.to_application = i_head.app[r_slot];
                n_result.last_of_run    = is_last;
                n_result.end_of_write   = is_last && i_head.fin;
                if (is_last) begin
                    o_pop  = 1'b1;
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_slot   <= n_slot;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_slot_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.empty |-> r_slot == '0) else $error("slot advanced with no entry");
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(!i_stat.empty)) else $error("beat without queued entry");
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stat.empty && i_head.cnt != '0 |-> {1'b0, r_slot} < i_head.cnt)
        else $error("slot past entry count");

endmodule
